FILE: rtl/rmo_pkg.sv
// ----------------------------------------------------------------------------
// rmo_pkg
// Widths, types and constants shared by the rotation matrix orthonormalizer
// and its port checker.
// ----------------------------------------------------------------------------
package rmo_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 13;
  localparam int ONE       = 1 << FRAC_BITS;

  // field widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 15;
  localparam int MN_W  = 15;

  // z column: squares, sum, root, division
  localparam int ZSQ_W  = 2 * IN_W - 1;
  localparam int ZS_W   = 2 * IN_W;
  localparam int NZ_W   = IN_W;
  localparam int ZQ_W   = FRAC_BITS + 1;
  localparam int ZNUM_W = IN_W + FRAC_BITS;

  // x column: cross product, squares, sum, root, division
  localparam int XP_W   = IN_W + OUT_W;
  localparam int X_W    = XP_W + 1;
  localparam int XM_W   = IN_W + FRAC_BITS + 1;
  localparam int XSQ_W  = 2 * XM_W - 1;
  localparam int XS_W   = 2 * XM_W;
  localparam int NX_W   = XM_W;
  localparam int XNUM_W = XM_W + FRAC_BITS;

  // y column: products and difference
  localparam int YP_W = 2 * OUT_W;
  localparam int YD_W = YP_W + 1;
  localparam int SM_W = YD_W - FRAC_BITS;

  // stream words
  localparam int TDI_W = 9 * IN_W;
  localparam int TDO_W = ((9 * OUT_W + 7) / 8) * 8;

  typedef logic signed [IN_W-1:0]  ent_t;
  typedef logic signed [OUT_W-1:0] res_t;

  // digit-by-digit square root state, z column
  typedef struct packed {
    logic [NZ_W-1:0]   r;
    logic [2*NZ_W:0]   sq;
    logic [ZS_W-1:0]   s;
  } zroot_t;

  // digit-by-digit square root state, x column
  typedef struct packed {
    logic [NX_W-1:0]   r;
    logic [2*NX_W:0]   sq;
    logic [XS_W-1:0]   s;
  } xroot_t;

  // restoring division state
  typedef struct packed {
    logic [ZNUM_W-1:0] rem;
    logic [ZQ_W-1:0]   q;
  } zdiv_t;

  typedef struct packed {
    logic [XNUM_W-1:0] rem;
    logic [ZQ_W-1:0]   q;
  } xdiv_t;

endpackage

FILE: rtl/rotation_matrix_orthonormalize.sv
// ----------------------------------------------------------------------------
// rotation_matrix_orthonormalize
// Fully pipelined orthonormalizer for a 3x3 Q3.13 matrix.
// ----------------------------------------------------------------------------
// One matrix enters per clock while the output word is not held. The
// pipeline is made of the two square roots (16 and 30 stages, one root bit per
// stage) and the two banks of three restoring dividers (14 stages each, one
// quotient bit per stage), plus the square, sum, product and output stages.
// The third column is normalized first, the first column is the normalized
// cross of the old second column with it, and the second column is their
// cross. A column shorter than min_norm returns the identity with tuser set.
// When the output word is held, the whole pipeline holds and s_tready drops.
// min_norm is written through the cfg channel, which is always ready.
module rotation_matrix_orthonormalize
  import rmo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata: row1_col1, row1_col2, ... row3_col3, 16 bits each
  input  logic [TDI_W-1:0] s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata: row1_col1, row1_col2, ... row3_col3, 15 bits each, zero pad
  output logic [TDO_W-1:0] m_tdata,
  // m_tuser: degenerate
  output logic [0:0]       m_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MN_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] mag16(input logic [IN_W-1:0] v);
    return v[IN_W-1] ? IN_W'(-v) : v;
  endfunction

  function automatic logic [X_W-1:0] mag32(input logic [X_W-1:0] v);
    return v[X_W-1] ? X_W'(-v) : v;
  endfunction

  function automatic logic [YD_W-1:0] mag31(input logic [YD_W-1:0] v);
    return v[YD_W-1] ? YD_W'(-v) : v;
  endfunction

  // clamp a magnitude to 1.0 and apply the sign
  function automatic res_t sat_one(input logic [SM_W-1:0] m, input logic neg);
    logic [OUT_W-1:0] c;
    c = (m > SM_W'(ONE)) ? OUT_W'(ONE) : m[OUT_W-1:0];
    return neg ? res_t'(OUT_W'(-c)) : res_t'(c);
  endfunction

  function automatic zroot_t zroot_step(input zroot_t a, input int b);
    logic [2*NZ_W:0] trial;
    zroot_t          o;
    o     = a;
    trial = a.sq + ({{(NZ_W+1){1'b0}}, a.r} << (b + 1)) + ((2*NZ_W+1)'(1) << (2 * b));
    if (trial <= {1'b0, a.s}) begin
      o.r  = a.r | (NZ_W'(1) << b);
      o.sq = trial;
    end
    return o;
  endfunction

  function automatic xroot_t xroot_step(input xroot_t a, input int b);
    logic [2*NX_W:0] trial;
    xroot_t          o;
    o     = a;
    trial = a.sq + ({{(NX_W+1){1'b0}}, a.r} << (b + 1)) + ((2*NX_W+1)'(1) << (2 * b));
    if (trial <= {1'b0, a.s}) begin
      o.r  = a.r | (NX_W'(1) << b);
      o.sq = trial;
    end
    return o;
  endfunction

  function automatic zdiv_t zdiv_step(input zdiv_t a, input logic [NZ_W-1:0] d,
                                      input int k);
    logic [ZNUM_W-1:0] ds;
    zdiv_t             o;
    o  = a;
    ds = {{(ZNUM_W-NZ_W){1'b0}}, d} << k;
    if (a.rem >= ds) begin
      o.rem = a.rem - ds;
      o.q   = a.q | (ZQ_W'(1) << k);
    end
    return o;
  endfunction

  function automatic xdiv_t xdiv_step(input xdiv_t a, input logic [NX_W-1:0] d,
                                      input int k);
    logic [XNUM_W-1:0] ds;
    xdiv_t             o;
    o  = a;
    ds = {{(XNUM_W-NX_W){1'b0}}, d} << k;
    if (a.rem >= ds) begin
      o.rem = a.rem - ds;
      o.q   = a.q | (ZQ_W'(1) << k);
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // configuration and flow control
  // --------------------------------------------------------------------------
  logic [MN_W-1:0] min_norm;
  logic            en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  // hold the threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= MN_W'(1);
    end else if (cfg_valid) begin
      min_norm <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  logic                in_v;
  ent_t                in_b [3];
  ent_t                in_z [3];

  logic                a1_v;
  ent_t                a1_b [3];
  ent_t                a1_z [3];
  logic [ZSQ_W-1:0]    a1_sq [3];

  logic                a2_v;
  ent_t                a2_b [3];
  ent_t                a2_z [3];
  logic [ZS_W-1:0]     a2_s;

  logic                sz_v [NZ_W];
  zroot_t              sz_a [NZ_W];
  ent_t                sz_b [NZ_W][3];
  ent_t                sz_z [NZ_W][3];

  logic                dz_v  [ZQ_W];
  logic [NZ_W-1:0]     dz_d  [ZQ_W];
  zdiv_t               dz_w  [ZQ_W][3];
  logic                dz_n  [ZQ_W][3];
  ent_t                dz_b  [ZQ_W][3];
  logic                dz_dg [ZQ_W];

  logic                c1_v;
  res_t                c1_zn [3];
  ent_t                c1_b  [3];
  logic                c1_dg;

  logic                c2_v;
  res_t                c2_zn [3];
  logic signed [XP_W-1:0] c2_p [6];
  logic                c2_dg;

  logic                c3_v;
  res_t                c3_zn [3];
  logic signed [X_W-1:0] c3_x [3];
  logic                c3_dg;

  logic                c4_v;
  res_t                c4_zn [3];
  logic [XM_W-1:0]     c4_xm [3];
  logic                c4_xn [3];
  logic [XSQ_W-1:0]    c4_sq [3];
  logic                c4_dg;

  logic                c5_v;
  res_t                c5_zn [3];
  logic [XM_W-1:0]     c5_xm [3];
  logic                c5_xn [3];
  logic [XS_W-1:0]     c5_s;
  logic                c5_dg;

  logic                sx_v  [NX_W];
  xroot_t              sx_a  [NX_W];
  logic [XM_W-1:0]     sx_xm [NX_W][3];
  logic                sx_xn [NX_W][3];
  res_t                sx_zn [NX_W][3];
  logic                sx_dg [NX_W];

  logic                dx_v  [ZQ_W];
  logic [NX_W-1:0]     dx_d  [ZQ_W];
  xdiv_t               dx_w  [ZQ_W][3];
  logic                dx_n  [ZQ_W][3];
  res_t                dx_zn [ZQ_W][3];
  logic                dx_dg [ZQ_W];

  logic                e1_v;
  res_t                e1_xn [3];
  res_t                e1_zn [3];
  logic                e1_dg;

  logic                e2_v;
  res_t                e2_xn [3];
  res_t                e2_zn [3];
  logic signed [YP_W-1:0] e2_p [6];
  logic                e2_dg;

  logic                e3_v;
  res_t                e3_xn [3];
  res_t                e3_zn [3];
  logic signed [YD_W-1:0] e3_y [3];
  logic                e3_dg;

  logic                out_v;
  res_t                out_res [9];
  logic                out_dg;

  // combinational feeds
  zroot_t              sz_init;
  xroot_t              sx_init;
  logic [X_W-1:0]      c4_mag [3];
  logic [XM_W-1:0]     c4_mag_t [3];
  logic [2*XM_W-1:0]   c4_prod [3];
  logic                dz_dg_in;
  logic                dx_dg_in;
  logic [NZ_W-1:0]     nz;
  logic [NX_W-1:0]     nx;
  res_t                y_sat [3];

  always_comb begin
    sz_init    = '0;
    sz_init.s  = a2_s;
    sx_init    = '0;
    sx_init.s  = c5_s;
    nz         = sz_a[NZ_W-1].r;
    nx         = sx_a[NX_W-1].r;
    dz_dg_in   = (nz == '0) || (nz < {1'b0, min_norm});
    dx_dg_in   = sx_dg[NX_W-1] || (nx == '0) ||
                 (nx < NX_W'({min_norm, {FRAC_BITS{1'b0}}}));
    for (int j = 0; j < 3; j++) begin
      c4_mag[j]   = mag32(c3_x[j]);
      c4_mag_t[j] = c4_mag[j][XM_W-1:0];
      c4_prod[j]  = c4_mag_t[j] * c4_mag_t[j];
      y_sat[j]    = sat_one(SM_W'(mag31(e3_y[j]) >> FRAC_BITS), e3_y[j][YD_W-1]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      a1_v  <= 1'b0;
      a2_v  <= 1'b0;
      c1_v  <= 1'b0;
      c2_v  <= 1'b0;
      c3_v  <= 1'b0;
      c4_v  <= 1'b0;
      c5_v  <= 1'b0;
      e1_v  <= 1'b0;
      e2_v  <= 1'b0;
      e3_v  <= 1'b0;
      out_v <= 1'b0;
      for (int k = 0; k < NZ_W; k++) sz_v[k] <= 1'b0;
      for (int k = 0; k < ZQ_W; k++) dz_v[k] <= 1'b0;
      for (int k = 0; k < NX_W; k++) sx_v[k] <= 1'b0;
      for (int k = 0; k < ZQ_W; k++) dx_v[k] <= 1'b0;
    end else if (en) begin
      in_v    <= s_tvalid;
      a1_v    <= in_v;
      a2_v    <= a1_v;
      sz_v[0] <= a2_v;
      for (int k = 1; k < NZ_W; k++) sz_v[k] <= sz_v[k-1];
      dz_v[0] <= sz_v[NZ_W-1];
      for (int k = 1; k < ZQ_W; k++) dz_v[k] <= dz_v[k-1];
      c1_v    <= dz_v[ZQ_W-1];
      c2_v    <= c1_v;
      c3_v    <= c2_v;
      c4_v    <= c3_v;
      c5_v    <= c4_v;
      sx_v[0] <= c5_v;
      for (int k = 1; k < NX_W; k++) sx_v[k] <= sx_v[k-1];
      dx_v[0] <= sx_v[NX_W-1];
      for (int k = 1; k < ZQ_W; k++) dx_v[k] <= dx_v[k-1];
      e1_v    <= dx_v[ZQ_W-1];
      e2_v    <= e1_v;
      e3_v    <= e2_v;
      out_v   <= e3_v;
    end
  end

  // z column: capture, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        in_b[j]  <= s_tdata[IN_W*(3*j+1) +: IN_W];
        in_z[j]  <= s_tdata[IN_W*(3*j+2) +: IN_W];
        a1_b[j]  <= in_b[j];
        a1_z[j]  <= in_z[j];
        a1_sq[j] <= ZSQ_W'({{IN_W{1'b0}}, mag16(in_z[j])} *
                           {{IN_W{1'b0}}, mag16(in_z[j])});
        a2_b[j]  <= a1_b[j];
        a2_z[j]  <= a1_z[j];
      end
      a2_s <= {1'b0, a1_sq[0]} + {1'b0, a1_sq[1]} + {1'b0, a1_sq[2]};
    end
  end

  // z length: one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      sz_a[0] <= zroot_step(sz_init, NZ_W - 1);
      for (int j = 0; j < 3; j++) begin
        sz_b[0][j] <= a2_b[j];
        sz_z[0][j] <= a2_z[j];
      end
      for (int k = 1; k < NZ_W; k++) begin
        sz_a[k] <= zroot_step(sz_a[k-1], NZ_W - 1 - k);
        for (int j = 0; j < 3; j++) begin
          sz_b[k][j] <= sz_b[k-1][j];
          sz_z[k][j] <= sz_z[k-1][j];
        end
      end
    end
  end

  // z divide: one quotient bit per stage, three lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dz_d[0]  <= nz;
      dz_dg[0] <= dz_dg_in;
      for (int j = 0; j < 3; j++) begin
        dz_w[0][j] <= zdiv_step('{rem: {mag16(sz_z[NZ_W-1][j]), {FRAC_BITS{1'b0}}},
                                   q: '0}, nz, ZQ_W - 1);
        dz_n[0][j] <= sz_z[NZ_W-1][j][IN_W-1];
        dz_b[0][j] <= sz_b[NZ_W-1][j];
      end
      for (int k = 1; k < ZQ_W; k++) begin
        dz_d[k]  <= dz_d[k-1];
        dz_dg[k] <= dz_dg[k-1];
        for (int j = 0; j < 3; j++) begin
          dz_w[k][j] <= zdiv_step(dz_w[k-1][j], dz_d[k-1], ZQ_W - 1 - k);
          dz_n[k][j] <= dz_n[k-1][j];
          dz_b[k][j] <= dz_b[k-1][j];
        end
      end
    end
  end

  // new z, cross products, x squares and sum
  always_ff @(posedge clk) begin
    if (en) begin
      c1_dg <= dz_dg[ZQ_W-1];
      c2_dg <= c1_dg;
      c3_dg <= c2_dg;
      c4_dg <= c3_dg;
      c5_dg <= c4_dg;
      for (int j = 0; j < 3; j++) begin
        c1_zn[j] <= sat_one({{(SM_W-ZQ_W){1'b0}}, dz_w[ZQ_W-1][j].q}, dz_n[ZQ_W-1][j]);
        c1_b[j]  <= dz_b[ZQ_W-1][j];
        c2_zn[j] <= c1_zn[j];
        c3_zn[j] <= c2_zn[j];
        c4_zn[j] <= c3_zn[j];
        c5_zn[j] <= c4_zn[j];
        c4_xm[j] <= c4_mag_t[j];
        c4_xn[j] <= c3_x[j][X_W-1];
        c4_sq[j] <= c4_prod[j][XSQ_W-1:0];
        c5_xm[j] <= c4_xm[j];
        c5_xn[j] <= c4_xn[j];
      end
      c2_p[0] <= c1_b[1] * c1_zn[2];
      c2_p[1] <= c1_b[2] * c1_zn[1];
      c2_p[2] <= c1_b[2] * c1_zn[0];
      c2_p[3] <= c1_b[0] * c1_zn[2];
      c2_p[4] <= c1_b[0] * c1_zn[1];
      c2_p[5] <= c1_b[1] * c1_zn[0];
      for (int j = 0; j < 3; j++) begin
        c3_x[j] <= X_W'(c2_p[2*j]) - X_W'(c2_p[2*j+1]);
      end
      c5_s <= {1'b0, c4_sq[0]} + {1'b0, c4_sq[1]} + {1'b0, c4_sq[2]};
    end
  end

  // x length: one root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      sx_a[0]  <= xroot_step(sx_init, NX_W - 1);
      sx_dg[0] <= c5_dg;
      for (int j = 0; j < 3; j++) begin
        sx_xm[0][j] <= c5_xm[j];
        sx_xn[0][j] <= c5_xn[j];
        sx_zn[0][j] <= c5_zn[j];
      end
      for (int k = 1; k < NX_W; k++) begin
        sx_a[k]  <= xroot_step(sx_a[k-1], NX_W - 1 - k);
        sx_dg[k] <= sx_dg[k-1];
        for (int j = 0; j < 3; j++) begin
          sx_xm[k][j] <= sx_xm[k-1][j];
          sx_xn[k][j] <= sx_xn[k-1][j];
          sx_zn[k][j] <= sx_zn[k-1][j];
        end
      end
    end
  end

  // x divide: one quotient bit per stage, three lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dx_d[0]  <= nx;
      dx_dg[0] <= dx_dg_in;
      for (int j = 0; j < 3; j++) begin
        dx_w[0][j]  <= xdiv_step('{rem: {sx_xm[NX_W-1][j], {FRAC_BITS{1'b0}}}, q: '0},
                                 nx, ZQ_W - 1);
        dx_n[0][j]  <= sx_xn[NX_W-1][j];
        dx_zn[0][j] <= sx_zn[NX_W-1][j];
      end
      for (int k = 1; k < ZQ_W; k++) begin
        dx_d[k]  <= dx_d[k-1];
        dx_dg[k] <= dx_dg[k-1];
        for (int j = 0; j < 3; j++) begin
          dx_w[k][j]  <= xdiv_step(dx_w[k-1][j], dx_d[k-1], ZQ_W - 1 - k);
          dx_n[k][j]  <= dx_n[k-1][j];
          dx_zn[k][j] <= dx_zn[k-1][j];
        end
      end
    end
  end

  // new x, second column, output word
  always_ff @(posedge clk) begin
    if (en) begin
      e1_dg <= dx_dg[ZQ_W-1];
      e2_dg <= e1_dg;
      e3_dg <= e2_dg;
      for (int j = 0; j < 3; j++) begin
        e1_xn[j] <= sat_one({{(SM_W-ZQ_W){1'b0}}, dx_w[ZQ_W-1][j].q}, dx_n[ZQ_W-1][j]);
        e1_zn[j] <= dx_zn[ZQ_W-1][j];
        e2_xn[j] <= e1_xn[j];
        e2_zn[j] <= e1_zn[j];
        e3_xn[j] <= e2_xn[j];
        e3_zn[j] <= e2_zn[j];
      end
      e2_p[0] <= e1_zn[1] * e1_xn[2];
      e2_p[1] <= e1_zn[2] * e1_xn[1];
      e2_p[2] <= e1_zn[2] * e1_xn[0];
      e2_p[3] <= e1_zn[0] * e1_xn[2];
      e2_p[4] <= e1_zn[0] * e1_xn[1];
      e2_p[5] <= e1_zn[1] * e1_xn[0];
      for (int j = 0; j < 3; j++) begin
        e3_y[j] <= YD_W'(e2_p[2*j]) - YD_W'(e2_p[2*j+1]);
      end
      // drop to the identity on a short column
      out_dg <= e3_dg;
      for (int j = 0; j < 3; j++) begin
        if (e3_dg) begin
          out_res[3*j]   <= (j == 0) ? res_t'(ONE) : '0;
          out_res[3*j+1] <= (j == 1) ? res_t'(ONE) : '0;
          out_res[3*j+2] <= (j == 2) ? res_t'(ONE) : '0;
        end else begin
          out_res[3*j]   <= e3_xn[j];
          out_res[3*j+1] <= y_sat[j];
          out_res[3*j+2] <= e3_zn[j];
        end
      end
    end
  end

  // pack the output word
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      m_tdata[OUT_W*i +: OUT_W] = out_res[i];
    end
  end

  assign m_tvalid   = out_v;
  assign m_tuser[0] = out_dg;

endmodule

FILE: rtl/rmo_checker.sv
// ----------------------------------------------------------------------------
// rmo_checker
// Port-level checks for the rotation matrix orthonormalizer.
// ----------------------------------------------------------------------------
module rmo_checker
  import rmo_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [TDO_W-1:0] m_tdata,
  input logic [0:0]       m_tuser
);

  // identity word, diagonal at 1.0
  localparam logic [TDO_W-1:0] IDENT =
    (TDO_W'(ONE)) | (TDO_W'(ONE) << (4 * OUT_W)) | (TDO_W'(ONE) << (8 * OUT_W));

  // hold a stalled output word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // a degenerate word is the identity
  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == IDENT)
    else $error("degenerate word is not the identity");

  // a held output stalls the input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // the first two diagonal entries stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[OUT_W-1:0]) <= $signed(OUT_W'(ONE)) &&
                 $signed(m_tdata[OUT_W-1:0]) >= -$signed(OUT_W'(ONE)) &&
                 $signed(m_tdata[5*OUT_W-1:4*OUT_W]) <= $signed(OUT_W'(ONE)) &&
                 $signed(m_tdata[5*OUT_W-1:4*OUT_W]) >= -$signed(OUT_W'(ONE)))
    else $error("diagonal entry out of range");

  // empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind rotation_matrix_orthonormalize rmo_checker u_rmo_checker (.*);
